// File: src/itba_pkg.sv
// Shared types and constants for the signed integer to base digits block.
// Used by itba_cfg, itba_ctrl, itba_dp and the top level; depends on nothing.
package itba_pkg;

    localparam int NUMBER_W   = 32;
    localparam int SYMBOL_W   = 8;
    localparam int COUNT_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int ALPHA_SIZE = 16;
    localparam int ALPHA_W    = ALPHA_SIZE * SYMBOL_W;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int DIGITS_MAX = 32;
    localparam int DEPTH_W    = $clog2(DIGITS_MAX + 1);
    // Numerator bits consumed per divider step, and steps per digit
    localparam int STEP_BITS  = 8;
    localparam int STEPS      = NUMBER_W / STEP_BITS;
    localparam int STEP_CNT_W = $clog2(STEPS);

    localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'h2B;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // latch sign and magnitude of the accepted beat
        logic div_step;    // run one divider step
        logic push;        // push the finished remainder, restart the remainder
        logic emit_sign;   // load the minus symbol into the output register
        logic emit_digit;  // pop one digit into the output register
    } itba_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic neg;         // held value is negative
        logic quo_zero;    // quotient of the digit in progress is zero
        logic stack_full;  // one digit slot left
        logic last_digit;  // one digit left in the stack
        logic out_free;    // output register can take a symbol this cycle
    } itba_stat_t;

endpackage

// File: src/itba_cfg.sv
// Configuration registers and alphabet check.
// Depends on itba_pkg.
module itba_cfg #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [itba_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [itba_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic [itba_pkg::COUNT_W-1:0]          digit_count,
    output logic [itba_pkg::ALPHA_W-1:0]          symbols,
    output logic                                  alpha_ok
);

    logic [itba_pkg::COUNT_W-1:0]  digit_count_reg;
    logic [itba_pkg::CFG_DATA_W-1:0] symbols_low_reg;
    logic [itba_pkg::CFG_DATA_W-1:0] symbols_high_reg;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg  <= '0;
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                itba_pkg::CFG_DIGIT_COUNT:
                    digit_count_reg <= cfg_data[itba_pkg::COUNT_W-1:0];
                itba_pkg::CFG_SYMBOLS_LOW:
                    symbols_low_reg <= cfg_data;
                itba_pkg::CFG_SYMBOLS_HIGH:
                    symbols_high_reg <= cfg_data;
                default:
                begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign digit_count = digit_count_reg;
    assign symbols     = {symbols_high_reg, symbols_low_reg};

    // Check length, sign symbols and repeats over the active symbols
    always_comb
    begin
        logic                               ok;
        logic [itba_pkg::SYMBOL_W-1:0]      sym_i;
        ok = (digit_count_reg >= itba_pkg::COUNT_W'(2)) &&
             (digit_count_reg <= itba_pkg::COUNT_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            sym_i = symbols[i*itba_pkg::SYMBOL_W +: itba_pkg::SYMBOL_W];
            if (itba_pkg::COUNT_W'(i) < digit_count_reg)
            begin
                if (sym_i == itba_pkg::SYM_PLUS || sym_i == itba_pkg::SYM_MINUS)
                    ok = 1'b0;
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if (itba_pkg::COUNT_W'(j) < digit_count_reg &&
                        symbols[j*itba_pkg::SYMBOL_W +: itba_pkg::SYMBOL_W] == sym_i)
                        ok = 1'b0;
                end
            end
        end
        alpha_ok = ok;
    end

endmodule

// File: src/itba_dp.sv
// Datapath: magnitude register, iterative divider, digit stack, output register.
// Depends on itba_pkg.
module itba_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  itba_pkg::itba_cmd_t                cmd,
    output itba_pkg::itba_stat_t               stat,
    input  logic [itba_pkg::NUMBER_W-1:0]      number,
    input  logic [itba_pkg::COUNT_W-1:0]       digit_count,
    input  logic [itba_pkg::ALPHA_W-1:0]       symbols,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [itba_pkg::SYMBOL_W-1:0]      out_symbol,
    output logic                               out_last
);

    logic                                   neg_reg;
    logic [itba_pkg::NUMBER_W-1:0]          mag_reg;
    logic [itba_pkg::DIGIT_W-1:0]           rem_reg;
    logic [itba_pkg::DIGITS_MAX-1:0][itba_pkg::DIGIT_W-1:0] stack_reg;
    logic [itba_pkg::DEPTH_W-1:0]           depth_reg;
    logic                                   out_valid_reg;
    logic [itba_pkg::SYMBOL_W-1:0]          out_symbol_reg;
    logic                                   out_last_reg;

    logic [itba_pkg::NUMBER_W-1:0]          mag_step;
    logic [itba_pkg::DIGIT_W-1:0]           rem_step;
    logic [itba_pkg::DIGIT_W-1:0]           top_digit;
    logic [itba_pkg::SYMBOL_W-1:0]          top_symbol;

    // One divider step: restoring division over the top byte of the magnitude
    always_comb
    begin
        logic [itba_pkg::COUNT_W-1:0]   trial;
        logic [itba_pkg::STEP_BITS-1:0] qbits;
        logic [itba_pkg::DIGIT_W-1:0]   r;
        r     = rem_reg;
        qbits = '0;
        for (int i = 0; i < itba_pkg::STEP_BITS; i++)
        begin
            trial = {r, mag_reg[itba_pkg::NUMBER_W-1-i]};
            if (trial >= digit_count)
            begin
                trial = trial - digit_count;
                qbits[itba_pkg::STEP_BITS-1-i] = 1'b1;
            end
            r = trial[itba_pkg::DIGIT_W-1:0];
        end
        rem_step = r;
        mag_step = {mag_reg[itba_pkg::NUMBER_W-itba_pkg::STEP_BITS-1:0], qbits};
    end

    // Look up the symbol of the digit on top of the stack
    assign top_digit  = stack_reg[0];
    assign top_symbol = symbols[{top_digit, 3'd0} +: itba_pkg::SYMBOL_W];

    // Hold magnitude, remainder and digit stack
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else if (cmd.load)
        begin
            depth_reg <= '0;
        end
        else if (cmd.push)
        begin
            depth_reg <= depth_reg + itba_pkg::DEPTH_W'(1);
        end
        else if (cmd.emit_digit)
        begin
            depth_reg <= depth_reg - itba_pkg::DEPTH_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= number[itba_pkg::NUMBER_W-1];
            mag_reg <= number[itba_pkg::NUMBER_W-1] ? (~number + itba_pkg::NUMBER_W'(1))
                                                    : number;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            mag_reg <= mag_step;
            rem_reg <= cmd.push ? '0 : rem_step;
        end
        if (cmd.push)
            stack_reg <= {stack_reg[itba_pkg::DIGITS_MAX-2:0], rem_step};
        else if (cmd.emit_digit)
            stack_reg <= {itba_pkg::DIGIT_W'(0), stack_reg[itba_pkg::DIGITS_MAX-1:1]};
    end

    // Output register: load a symbol, drop it once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_sign || cmd.emit_digit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_sign)
        begin
            out_symbol_reg <= itba_pkg::SYM_MINUS;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_symbol_reg <= top_symbol;
            out_last_reg   <= stat.last_digit;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_symbol_reg;
    assign out_last   = out_last_reg;

    assign stat.neg        = neg_reg;
    assign stat.quo_zero   = (mag_step == '0);
    assign stat.stack_full = (depth_reg == itba_pkg::DEPTH_W'(itba_pkg::DIGITS_MAX - 1));
    assign stat.last_digit = (depth_reg == itba_pkg::DEPTH_W'(1));
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

// File: src/itba_ctrl.sv
// Controller: sequences accept, check, division steps and symbol output.
// Depends on itba_pkg.
module itba_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    alpha_ok,
    input  itba_pkg::itba_stat_t    stat,
    output itba_pkg::itba_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                              state_reg, state_next;
    logic [itba_pkg::STEP_CNT_W-1:0]     step_reg, step_next;
    logic                                last_step;

    assign last_step = (step_reg == itba_pkg::STEP_CNT_W'(itba_pkg::STEPS - 1));

    // Decode state into commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                step_next  = '0;
                state_next = alpha_ok ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + itba_pkg::STEP_CNT_W'(1);
                if (last_step)
                begin
                    cmd.push = 1'b1;
                    if (stat.quo_zero || stat.stack_full)
                        state_next = stat.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (stat.last_digit)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: src/signed_integer_to_base_digits.sv
// Top level: signed 32-bit value to text in a configurable base.
// Depends on itba_pkg, itba_cfg, itba_ctrl and itba_dp.
//
//   channel   direction  beat contents
//   s_axis    in         tdata[31:0] number
//   m_axis    out        tdata[7:0] symbol, tlast final_res
//   cfg       in         cfg_index selects register, cfg_data value
//
// One item at a time: the beat is accepted, then the alphabet is checked, then
// the divider forms each digit in steps (8 quotient bits per cycle), then the
// minus sign, if negative, and the digit symbols go out, one per output beat.
// An item whose alphabet check fails is dropped with no output.
// Reset clears configuration to zero, the controller to idle and the output
// register to empty. A stall on m_axis holds the controller in the output
// states; the last symbol can wait in the output register while the next
// beat is accepted.
module signed_integer_to_base_digits #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [itba_pkg::NUMBER_W-1:0]         s_axis_tdata,   // [31:0] number
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [itba_pkg::SYMBOL_W-1:0]         m_axis_tdata,   // [7:0] symbol
    output logic                                  m_axis_tlast,   // final_res
    input  logic                                  cfg_we,
    input  logic [itba_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [itba_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [itba_pkg::COUNT_W-1:0]  digit_count;
    logic [itba_pkg::ALPHA_W-1:0]  symbols;
    logic                          alpha_ok;
    itba_pkg::itba_cmd_t           cmd;
    itba_pkg::itba_stat_t          stat;

    itba_cfg #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .digit_count (digit_count),
        .symbols     (symbols),
        .alpha_ok    (alpha_ok)
    );

    itba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .alpha_ok (alpha_ok),
        .stat     (stat),
        .cmd      (cmd)
    );

    itba_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .number      (s_axis_tdata),
        .digit_count (digit_count),
        .symbols     (symbols),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_symbol  (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

endmodule
